// ===== design/bcnf_pkg.sv =====
package bcnf_pkg;

    localparam int SECTIONS   = 9;
    localparam int COEF_WIDTH = 32;
    localparam int DATA_WIDTH = 24;

    localparam int ROM_ROWS   = 9;
    localparam int TAPS       = 5;
    localparam int WORD_W     = 32;

    localparam int COEF_W     = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;
    localparam int CF         = COEF_W - 2;
    localparam int COEF_SHIFT = 30 - CF;
    localparam int HF         = WORD_W - DATA_WIDTH;
    localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8;

    localparam int PROD_W     = COEF_W + WORD_W;
    localparam int ACC_W      = PROD_W + 3;

    localparam int SEC_W      = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTIONS - 1);

    localparam logic signed [63:0] ROM_ONE   = 64'sd1073741824;
    localparam logic signed [63:0] COEF_RND  = (64'sd1 <<< COEF_SHIFT) >>> 1;

    // Rows of {b0, b1, b2, a1, a2} in Q2.30; a1 and a2 are already negated.
    localparam logic signed [31:0] COEF_ROM [2][ROM_ROWS][TAPS] = '{
        '{
            '{32'sd1067864034, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
            '{32'sd1073741824, -32'sd2042741205, 32'sd1073741824,
              32'sd2022317515, -32'sd1061705134},
            '{32'sd1067864034, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
            '{32'sd1073741824, -32'sd2042741205, 32'sd1073741824,
              32'sd2040456535, -32'sd1062633111},
            '{32'sd1059860370, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
            '{32'sd1073741824, -32'sd2042741205, 32'sd1073741824,
              32'sd2012320771, -32'sd1045552405},
            '{32'sd1059860370, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
            '{32'sd1073741824, -32'sd2042741205, 32'sd1073741824,
              32'sd2020286373, -32'sd1046467886},
            '{32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0}
        },
        '{
            '{32'sd1049886928, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
            '{32'sd1073741824, -32'sd665499693, 32'sd1073741824,
              32'sd546403692, -32'sd1028097763},
            '{32'sd1049886928, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
            '{32'sd1073741824, -32'sd665499693, 32'sd1073741824,
              32'sd753361625, -32'sd1029577635},
            '{32'sd1020748874, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
            '{32'sd1073741824, -32'sd665499693, 32'sd1073741824,
              32'sd590679774, -32'sd967524298},
            '{32'sd1020748874, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
            '{32'sd1073741824, -32'sd665499693, 32'sd1073741824,
              32'sd674367888, -32'sd968926597},
            '{32'sd1073741824, 32'sd0, 32'sd0, 32'sd0, 32'sd0}
        }
    };

    typedef enum logic [2:0] {
        TAP_X,
        TAP_X1,
        TAP_X2,
        TAP_Y1,
        TAP_Y2
    } tap_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_WB,
        S_DONE
    } state_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] in1;
        logic signed [WORD_W-1:0] in2;
        logic signed [WORD_W-1:0] out1;
        logic signed [WORD_W-1:0] out2;
    } hist_word_t;

    typedef struct packed {
        logic             clear;
        logic             rd_en;
        logic [SEC_W-1:0] rd_addr;
        logic             wr_en;
        logic [SEC_W-1:0] wr_addr;
    } hist_ctrl_t;

    typedef struct packed {
        logic clear;
        logic mul_en;
    } mac_ctrl_t;

    // Coefficient in use for a section and tap, rounded to CF fraction bits.
    function automatic logic signed [COEF_W-1:0] coef_at(
        input logic             sel,
        input logic [SEC_W-1:0] sec,
        input tap_t             k
    );
        logic signed [63:0] t;
        logic signed [63:0] r;
        if (int'(sec) >= ROM_ROWS)
        begin
            t = (k == TAP_X) ? ROM_ONE : 64'sd0;
        end
        else
        begin
            t = 64'(COEF_ROM[sel][sec][k]);
        end
        r = (t + COEF_RND) >>> COEF_SHIFT;
        return r[COEF_W-1:0];
    endfunction

endpackage

// ===== design/bcnf_hist_ram.sv =====
module bcnf_hist_ram
    import bcnf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  hist_ctrl_t ctrl,
    input  hist_word_t wr_data,
    output hist_word_t rd_data
);

    hist_word_t          mem [SECTIONS];
    hist_word_t          rd_word_reg;
    logic [SECTIONS-1:0] valid_reg;
    logic                rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_word_reg <= mem[ctrl.rd_addr];
        end
    end

    // An entry that has not been written since reset or a clear reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctrl.wr_en)
            begin
                valid_reg[ctrl.wr_addr] <= 1'b1;
            end
            if (ctrl.rd_en)
            begin
                rd_valid_reg <= valid_reg[ctrl.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

// ===== design/bcnf_mac.sv =====
module bcnf_mac
    import bcnf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_ctrl_t                ctrl,
    input  logic signed [COEF_W-1:0] coef,
    input  logic signed [WORD_W-1:0] operand,
    output logic signed [WORD_W-1:0] y
);

    localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1) <<< (CF - 1);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_shift;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= coef * operand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= ctrl.mul_en;
            if (ctrl.clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    // Round to nearest, ties upward, then saturate to a 32-bit history word.
    always_comb
    begin
        acc_shift = (acc_reg + ACC_RND) >>> CF;
        if ((acc_shift[ACC_W-1:WORD_W-1] == '0) || (acc_shift[ACC_W-1:WORD_W-1] == '1))
        begin
            y = acc_shift[WORD_W-1:0];
        end
        else if (acc_shift[ACC_W-1])
        begin
            y = {1'b1, {(WORD_W-1){1'b0}}};
        end
        else
        begin
            y = {1'b0, {(WORD_W-1){1'b1}}};
        end
    end

endmodule

// ===== design/biquad_cascade_notch_filter_top.sv =====
// Nine direct-form-I biquad sections in cascade: four notches and five gains.
//
// Input words arrive on s_axis (sample_in, signed, in tdata) and filtered
// words leave on m_axis (sample_out, signed, in tdata). cfg_wr_en with
// cfg_wr_data selects the coefficient set (0: 1 kHz, 1: 250 Hz) and clears
// the history of every section; write it only while the block is idle.
//
// Each word is processed one section after another on a single shared
// multiply-accumulate unit. A section steps through five multiplies, one
// accumulate and one write-back that also reads the next section's history
// from the history memory. The result becomes valid in the same cycle as
// s_axis_tready returns, so a new word is only taken once the last one is
// through all nine sections.
//
// The result sits in an output register; the next input word is accepted and
// filtered while it waits. Only if the receiver still stalls when the next
// result is ready does the block hold, and s_axis_tready stays low.
// Reset zeroes the history, selects the 1 kHz set and empties the output.
module biquad_cascade_notch_filter_top
    import bcnf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // [23:0] sample_in
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [23:0] sample_out
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data
);

    state_t                   state_reg;
    state_t                   state_next;
    logic [SEC_W-1:0]         sec_reg;
    tap_t                     tap_reg;
    logic signed [WORD_W-1:0] x_reg;
    logic                     rate_sel_reg;
    logic                     out_valid_reg;
    logic [DATA_WIDTH-1:0]    out_data_reg;

    logic                     in_acc;
    logic                     out_free;
    hist_ctrl_t               hctl;
    mac_ctrl_t                mctl;
    hist_word_t               hist_rd;
    hist_word_t               hist_wr;
    logic signed [COEF_W-1:0] coef;
    logic signed [WORD_W-1:0] operand;
    logic signed [WORD_W-1:0] y;
    logic signed [WORD_W:0]   out_round;
    logic [DATA_WIDTH-1:0]    out_sat;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    bcnf_hist_ram u_hist
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (hctl),
        .wr_data (hist_wr),
        .rd_data (hist_rd)
    );

    bcnf_mac u_mac
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mctl),
        .coef    (coef),
        .operand (operand),
        .y       (y)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (tap_reg == TAP_Y2)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                state_next = (sec_reg == SEC_LAST) ? S_DONE : S_MUL;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        hctl          = '0;
        mctl          = '0;
        hctl.clear    = cfg_wr_en;
        hctl.wr_addr  = sec_reg;
        hctl.rd_addr  = sec_reg;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                hctl.rd_en    = s_axis_tvalid;
                hctl.rd_addr  = '0;
                mctl.clear    = 1'b1;
            end
            S_MUL:
            begin
                mctl.mul_en = 1'b1;
            end
            S_WB:
            begin
                hctl.wr_en   = 1'b1;
                hctl.rd_en   = (sec_reg != SEC_LAST);
                hctl.rd_addr = sec_reg + SEC_W'(1);
                mctl.clear   = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        case (tap_reg)
            TAP_X:   operand = x_reg;
            TAP_X1:  operand = hist_rd.in1;
            TAP_X2:  operand = hist_rd.in2;
            TAP_Y1:  operand = hist_rd.out1;
            TAP_Y2:  operand = hist_rd.out2;
            default: operand = '0;
        endcase
    end

    assign coef = coef_at(rate_sel_reg, sec_reg, tap_reg);

    always_comb
    begin
        hist_wr.in1  = x_reg;
        hist_wr.in2  = hist_rd.in1;
        hist_wr.out1 = y;
        hist_wr.out2 = hist_rd.out1;
    end

    // Final word back to a sample: round away the fraction bits and saturate.
    always_comb
    begin
        out_round = ((WORD_W+1)'(x_reg) + ((WORD_W+1)'(1 << HF) >>> 1)) >>> HF;
        if ((out_round[WORD_W:DATA_WIDTH-1] == '0) || (out_round[WORD_W:DATA_WIDTH-1] == '1))
        begin
            out_sat = out_round[DATA_WIDTH-1:0];
        end
        else if (out_round[WORD_W])
        begin
            out_sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end
        else
        begin
            out_sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sec_reg       <= '0;
            tap_reg       <= TAP_X;
            rate_sel_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                rate_sel_reg <= cfg_wr_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    sec_reg <= '0;
                    tap_reg <= TAP_X;
                end
                S_MUL:
                begin
                    tap_reg <= tap_t'(tap_reg + 3'd1);
                end
                S_WB:
                begin
                    tap_reg <= TAP_X;
                    if (sec_reg != SEC_LAST)
                    begin
                        sec_reg <= sec_reg + SEC_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_reg <= {s_axis_tdata[DATA_WIDTH-1:0], {HF{1'b0}}};
        end
        else if (state_reg == S_WB)
        begin
            x_reg <= y;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            out_data_reg <= out_sat;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'(out_data_reg);

    // An accepted word always starts on the first section with the input tap.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == S_MUL) && (sec_reg == '0) && (tap_reg == TAP_X))
        else $error("word did not start on the first section");

    // Write-back of the last section leads straight to the result.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB) && (sec_reg == SEC_LAST) |=> (state_reg == S_DONE))
        else $error("last section did not finish the word");

    // A pending result is never overwritten while the receiver stalls.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(out_data_reg))
        else $error("stalled result changed");

    // The multiplier is only fed within a section's tap range.
    a_tap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (tap_reg != TAP_Y2) || (state_next == S_ACC))
        else $error("tap counter ran past the last tap");

endmodule

// ===== test/biquad_cascade_notch_filter_top_tb.sv =====
module biquad_cascade_notch_filter_top_tb
    import bcnf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES      = 6;
    localparam int RANDOM_ITEMS = 270;
    localparam int HOLD_CYCLES = 800;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_REPORTS = 10;

    typedef logic signed [DATA_WIDTH-1:0] sample_t;
    typedef logic signed [71:0] wide_t;

    typedef enum int {
        BURST_UNIFORM,
        BURST_SMALL,
        BURST_SQUARE,
        BURST_EXTREME,
        BURST_WALK
    } burst_kind_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;   // [23:0] sample_in
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;        // [23:0] sample_out
    logic               cfg_wr_en = 1'b0;
    logic               cfg_wr_data = 1'b0;

    biquad_cascade_notch_filter_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #10 clk = ~clk;

    sample_t pending_samples[$];
    sample_t expected_out[$];

    int  send_idle_pct = 16;
    int  recv_stall_pct = 79;
    bit  hold_request = 1'b0;
    int  hold_left = 0;
    int  fail_count = 0;
    int  reports = 0;
    int  quiet_cycles = 0;

    // Filter state kept alongside the block.
    logic                     coef_set = 1'b0;
    logic signed [WORD_W-1:0] sec_in_z1 [SECTIONS];
    logic signed [WORD_W-1:0] sec_in_z2 [SECTIONS];
    logic signed [WORD_W-1:0] sec_out_z1 [SECTIONS];
    logic signed [WORD_W-1:0] sec_out_z2 [SECTIONS];

    function automatic wide_t round_half_up(input wide_t v, input int n);
        if (n == 0)
        begin
            return v;
        end
        return (v + (wide_t'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic wide_t saturate(input wide_t v, input int bits);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (bits - 1)) - wide_t'(1);
        lo = -hi - wide_t'(1);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic wide_t tap_coef(input int sec, input int k);
        wide_t t;
        if (sec >= ROM_ROWS)
        begin
            // Sections past the table simply pass their input word through.
            t = (k == int'(TAP_X)) ? wide_t'(ROM_ONE) : wide_t'(0);
        end
        else
        begin
            t = COEF_ROM[coef_set][sec][k];
        end
        return round_half_up(t, 30 - CF);
    endfunction

    function automatic sample_t filter_sample(input sample_t s);
        logic signed [WORD_W-1:0] x;
        logic signed [WORD_W-1:0] y;
        logic signed [WORD_W-1:0] taps [TAPS];
        wide_t acc;
        wide_t cw;
        wide_t hw;
        x = s;
        x = x <<< HF;
        for (int i = 0; i < SECTIONS; i++)
        begin
            taps[TAP_X]  = x;
            taps[TAP_X1] = sec_in_z1[i];
            taps[TAP_X2] = sec_in_z2[i];
            taps[TAP_Y1] = sec_out_z1[i];
            taps[TAP_Y2] = sec_out_z2[i];
            acc = '0;
            for (int k = 0; k < TAPS; k++)
            begin
                cw = tap_coef(i, k);
                hw = taps[k];
                acc = acc + cw * hw;
            end
            acc = saturate(round_half_up(acc, CF), WORD_W);
            y = acc[WORD_W-1:0];
            sec_in_z2[i]  = sec_in_z1[i];
            sec_in_z1[i]  = x;
            sec_out_z2[i] = sec_out_z1[i];
            sec_out_z1[i] = y;
            x = y;
        end
        acc = x;
        acc = saturate(round_half_up(acc, HF), DATA_WIDTH);
        return acc[DATA_WIDTH-1:0];
    endfunction

    // Queues one run of random samples of a randomly chosen character and
    // returns its length.
    function automatic int add_burst();
        burst_kind_t kind;
        int len;
        int level;
        int amp;
        int half;
        kind = burst_kind_t'($urandom_range(int'(BURST_WALK), int'(BURST_UNIFORM)));
        len = $urandom_range(40, 8);
        level = $urandom_range(16777215) - 8388608;
        amp = $urandom_range(8388607);
        half = $urandom_range(32, 1);
        for (int n = 0; n < len; n++)
        begin
            case (kind)
                BURST_UNIFORM: level = $urandom_range(16777215) - 8388608;
                BURST_SMALL:   level = $urandom_range(511) - 256;
                BURST_SQUARE:  level = ((n / half) % 2 == 0) ? amp : -amp - 1;
                BURST_EXTREME:
                begin
                    case ($urandom_range(3))
                        0: level = 8388607;
                        1: level = -8388608;
                        2: level = 0;
                        default: level = -1;
                    endcase
                end
                default:
                begin
                    level = level + $urandom_range(262143) - 131072;
                    level = (level > 8388607) ? 8388607 : level;
                    level = (level < -8388608) ? -8388608 : level;
                end
            endcase
            pending_samples.push_back(sample_t'(level));
        end
        return len;
    endfunction

    always @(posedge clk)
    begin : drive_samples
        logic [TDATA_W-1:0] word;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_out.push_back(filter_sample(s_axis_tdata[DATA_WIDTH-1:0]));
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                word = '0;
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    word[DATA_WIDTH-1:0] = pending_samples.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    word[DATA_WIDTH-1:0] = sample_t'($urandom);
                    s_axis_tvalid <= 1'b0;
                end
                s_axis_tdata <= word;
            end
        end
    end

    always @(posedge clk)
    begin : receive_samples
        sample_t want;
        sample_t got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[DATA_WIDTH-1:0];
                if (expected_out.size() == 0)
                begin
                    fail_count++;
                    if (reports < MAX_REPORTS)
                    begin
                        $display("Unexpected output word %0d", got);
                        reports++;
                    end
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (reports < MAX_REPORTS)
                        begin
                            $display("sample_out mismatch: expected %0d, got %0d", want, got);
                            reports++;
                        end
                    end
                end
            end
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                cfg_wr_en)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin : run_phases
        sample_t directed_samples [12];
        logic    phase_rate [PHASES];
        int      phase_idle [PHASES];
        int      phase_stall [PHASES];
        int      queued;
        // Full scale, sign and bit patterns, then steps and a full-scale
        // alternation to push the sections towards overflow.
        directed_samples = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF,
                             24'h000001, 24'h555555, 24'hAAAAAA, 24'h7FFFFF,
                             24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF};
        phase_rate  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        phase_idle  = '{16, 16, 79, 79, 0, 0};
        phase_stall = '{79, 79, 16, 16, 0, 0};
        for (int i = 0; i < SECTIONS; i++)
        begin
            sec_in_z1[i] = '0;
            sec_in_z2[i] = '0;
            sec_out_z1[i] = '0;
            sec_out_z2[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++)
        begin
            // The block is idle here: nothing queued, offered or outstanding.
            do
                @(negedge clk);
            while (pending_samples.size() != 0 || s_axis_tvalid || expected_out.size() != 0);
            @(posedge clk);
            cfg_wr_en <= 1'b1;
            cfg_wr_data <= phase_rate[p];
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            cfg_wr_data <= 1'($urandom);
            coef_set = phase_rate[p];
            for (int i = 0; i < SECTIONS; i++)
            begin
                sec_in_z1[i] = '0;
                sec_in_z2[i] = '0;
                sec_out_z1[i] = '0;
                sec_out_z2[i] = '0;
            end
            @(negedge clk);
            send_idle_pct = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            if (p < 2)
            begin
                foreach (directed_samples[n])
                begin
                    pending_samples.push_back(directed_samples[n]);
                end
            end
            queued = 0;
            while (queued < RANDOM_ITEMS)
            begin
                queued += add_burst();
            end
            // Long receiver stall so that the output register and the
            // filter both fill and the input word is held back.
            if (p == 2)
            begin
                hold_request = 1'b1;
            end
        end

        do
            @(negedge clk);
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_out.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        fail_count += expected_out.size();
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
